// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on the clock, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert a next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/dece_pkg.sv
// Package for the directed Euler circuit engine: types, constants, codes.
// No dependencies.
`timescale 1ns / 1ps
package dece_pkg;
    localparam int MAX_VERTICES = 8;
    localparam int LIST_DEPTH   = 64;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int LW = $clog2(LIST_DEPTH);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_CHECK  = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_DEGREE   = 3'd2;
    localparam logic [2:0] ST_CONNECT  = 3'd3;
    localparam logic [2:0] ST_VERTEX   = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] from_vertex;
        logic [3:0] to_vertex;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       edge_present;
        logic [2:0] circuit_vertex;
        logic [5:0] edge_total;
        logic       last;
    } result_item_t;
endpackage

// File: sv/dece_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dece_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/directed_euler_circuit_engine.sv
// Directed Euler circuit engine: adjacency matrix in flops, circuit list in RAMs.
// Uses dece_pkg and dece_ram.
//
// Edge commands (add, remove, query) give one result. A run check copies the
// matrix, checks degrees vertex by vertex, runs reachability in n passes over
// n rows, then builds the tour by Hierholzer splicing in a linked list held in
// two 64-entry RAMs. A scan for a vertex with unused edges reads list entries
// one by one and restarts from the head after each sub-tour; each edge is
// spliced in by S_EXT, S_EXTW and S_LINK, and a sub-tour closes in S_EXT. The
// tour then streams out one vertex per result, each read from the list RAM.
// Results cannot be stalled: each is shown for one cycle with out_valid. busy
// drops in the cycle the last result is shown, so the next item can be taken
// at the edge that ends that cycle.
`timescale 1ns / 1ps
module directed_euler_circuit_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  dece_pkg::cmd_item_t     cmd,
    input  logic                    cfg_we,
    input  logic [3:0]              cfg_data,
    output logic                    out_valid,
    output dece_pkg::result_item_t  result
);
    import dece_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_EDGE   = 13'b0000000000010,
        S_COPY   = 13'b0000000000100,
        S_DEG    = 13'b0000000001000,
        S_REACH  = 13'b0000000010000,
        S_INIT   = 13'b0000000100000,
        S_SCAN   = 13'b0000001000000,
        S_SCANW  = 13'b0000010000000,
        S_EXT    = 13'b0000100000000,
        S_EXTW   = 13'b0001000000000,
        S_LINK   = 13'b0010000000000,
        S_EMIT   = 13'b0100000000000,
        S_EMITW  = 13'b1000000000000
    } state_t;

    state_t state_reg;
    logic [3:0] vcount_reg;
    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] work_reg [MAX_VERTICES];
    logic [5:0] edges_reg;
    cmd_item_t cmd_reg;
    logic [VW-1:0] i_reg;
    logic [VW-1:0] k_reg;
    logic [MAX_VERTICES-1:0] vis_reg, back_reg;
    logic [LW:0] count_reg;
    logic [LW-1:0] tail_reg, p_reg, ins_reg, kk_reg;
    logic [VW-1:0] v_reg;
    logic ov_reg;
    result_item_t res_reg;

    // n clamped 1..MAX_VERTICES
    logic [3:0] n;
    logic [MAX_VERTICES-1:0] mask;
    always_comb
    begin
        n = vcount_reg;
        if (n == 4'd0) n = 4'd1;
        if (n > 4'(MAX_VERTICES)) n = 4'(MAX_VERTICES);
        mask = MAX_VERTICES'((9'd1 << n) - 9'd1);
    end

    // list RAMs
    logic vl_we, nl_we;
    logic [LW-1:0] vl_wa, nl_wa, vl_ra, nl_ra;
    logic [VW-1:0] vl_wd, vl_rd;
    logic [LW-1:0] nl_wd, nl_rd;

    dece_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_vlist (
        .clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));
    dece_ram #(.WIDTH(LW), .DEPTH(LIST_DEPTH)) u_nlist (
        .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(nl_ra), .rdata(nl_rd));

    // edge decode and the result of an edge command
    logic evalid, present, bit_next;
    logic [VW-1:0] er, ec;
    logic [5:0] edges_next;
    result_item_t edge_res;
    always_comb
    begin
        evalid = cmd_reg.from_vertex != cmd_reg.to_vertex && cmd_reg.from_vertex != 4'd0
              && cmd_reg.to_vertex != 4'd0 && cmd_reg.from_vertex <= n
              && cmd_reg.to_vertex <= n;
        er = VW'(cmd_reg.from_vertex - 4'd1);
        ec = VW'(cmd_reg.to_vertex - 4'd1);
        present = adj_reg[er][ec];
        bit_next = present;
        edges_next = edges_reg;
        edge_res.status = evalid ? ST_DONE : ST_INVALID;
        edge_res.edge_present = 1'b0;
        edge_res.circuit_vertex = '0;
        edge_res.last = 1'b1;
        if (evalid)
        begin
            case (cmd_reg.command)
                CMD_ADD:
                begin
                    bit_next = 1'b1;
                    edge_res.edge_present = 1'b1;
                    if (!present) edges_next = edges_reg + 6'd1;
                end
                CMD_REMOVE:
                begin
                    bit_next = 1'b0;
                    if (present) edges_next = edges_reg - 6'd1;
                end
                default: edge_res.edge_present = present;
            endcase
        end
        edge_res.edge_total = edges_next;
    end

    // degree of vertex i
    logic [3:0] indeg, outdeg;
    always_comb
    begin
        indeg = '0;
        outdeg = '0;
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            indeg  = indeg + 4'(work_reg[j][i_reg]);
            outdeg = outdeg + 4'(work_reg[i_reg][j]);
        end
    end

    // lowest set bit of current row
    logic [VW-1:0] low_u;
    always_comb
    begin
        low_u = '0;
        for (int j = MAX_VERTICES - 1; j >= 0; j--)
        begin
            if (work_reg[v_reg][j]) low_u = VW'(j);
        end
    end

    logic last_i, deg_fail, conn_fail;
    assign last_i = ({1'b0, i_reg} == n - 4'd1);
    assign deg_fail = indeg != outdeg;
    assign conn_fail = ((vis_reg & mask) != mask) || ((back_reg & mask) != mask);

    always_comb
    begin
        vl_we = 1'b0; nl_we = 1'b0;
        vl_wa = '0; nl_wa = '0; vl_wd = '0; nl_wd = '0;
        vl_ra = p_reg; nl_ra = p_reg;
        case (state_reg)
            S_INIT:
            begin
                vl_we = 1'b1; nl_we = 1'b1;
            end
            S_EXT:
            begin
                nl_ra = ins_reg;
            end
            // new entry takes the old successor of ins
            S_EXTW:
            begin
                vl_we = 1'b1; vl_wa = count_reg[LW-1:0]; vl_wd = low_u;
                nl_we = 1'b1; nl_wa = count_reg[LW-1:0]; nl_wd = nl_rd;
            end
            // then ins points at the new entry
            S_LINK:
            begin
                nl_we = 1'b1; nl_wa = ins_reg; nl_wd = count_reg[LW-1:0];
            end
            default: ;
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign out_valid = ov_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcount_reg <= 4'd8;
            edges_reg <= '0;
            ov_reg <= 1'b0;
            vis_reg <= '0;
            for (int j = 0; j < MAX_VERTICES; j++) adj_reg[j] <= '0;
        end
        else
        begin
            ov_reg <= (state_reg == S_EDGE) || (state_reg == S_DEG && deg_fail)
                   || (state_reg == S_INIT && conn_fail) || (state_reg == S_EMITW);
            if (cfg_we) vcount_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        i_reg <= '0;
                        state_reg <= (cmd.command == CMD_CHECK) ? S_COPY : S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    res_reg <= edge_res;
                    edges_reg <= edges_next;
                    if (evalid) adj_reg[er][ec] <= bit_next;
                    state_reg <= S_IDLE;
                end
                S_COPY:
                begin
                    for (int j = 0; j < MAX_VERTICES; j++)
                        work_reg[j] <= (4'(j) < n) ? (adj_reg[j] & mask) : '0;
                    i_reg <= '0;
                    state_reg <= S_DEG;
                end
                S_DEG:
                begin
                    if (deg_fail)
                    begin
                        res_reg <= '{ST_DEGREE, 1'b0, '0, edges_reg, 1'b1};
                        state_reg <= S_IDLE;
                    end
                    else if (last_i)
                    begin
                        vis_reg <= MAX_VERTICES'(1); back_reg <= MAX_VERTICES'(1);
                        i_reg <= '0; k_reg <= '0;
                        state_reg <= S_REACH;
                    end
                    else i_reg <= i_reg + 1'b1;
                end
                S_REACH:
                begin
                    if (vis_reg[i_reg]) vis_reg <= vis_reg | work_reg[i_reg];
                    if ((work_reg[i_reg] & back_reg) != 0) back_reg[i_reg] <= 1'b1;
                    if (last_i)
                    begin
                        i_reg <= '0;
                        if ({1'b0, k_reg} == n - 4'd1) state_reg <= S_INIT;
                        else k_reg <= k_reg + 1'b1;
                    end
                    else i_reg <= i_reg + 1'b1;
                end
                S_INIT:
                begin
                    if (conn_fail)
                    begin
                        res_reg <= '{ST_CONNECT, 1'b0, '0, edges_reg, 1'b1};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        count_reg <= (LW+1)'(1); tail_reg <= '0; p_reg <= '0; kk_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: state_reg <= S_SCANW;
                S_SCANW:
                begin
                    if (work_reg[vl_rd] != 0)
                    begin
                        ins_reg <= p_reg; v_reg <= vl_rd;
                        state_reg <= S_EXT;
                    end
                    else if (p_reg == tail_reg)
                    begin
                        p_reg <= '0; kk_reg <= '0; state_reg <= S_EMIT;
                    end
                    else
                    begin
                        p_reg <= nl_rd; state_reg <= S_SCAN;
                    end
                end
                S_EXT:
                begin
                    if (work_reg[v_reg] == 0)
                    begin
                        p_reg <= '0; state_reg <= S_SCAN;
                    end
                    else state_reg <= S_EXTW;
                end
                S_EXTW:
                begin
                    work_reg[v_reg][low_u] <= 1'b0;
                    if (ins_reg == tail_reg) tail_reg <= count_reg[LW-1:0];
                    v_reg <= low_u;
                    state_reg <= S_LINK;
                end
                S_LINK:
                begin
                    ins_reg <= count_reg[LW-1:0];
                    count_reg <= count_reg + 1'b1;
                    if (count_reg + 1'b1 >= (LW+1)'(LIST_DEPTH))
                    begin
                        p_reg <= '0; kk_reg <= '0; state_reg <= S_EMIT;
                    end
                    else state_reg <= S_EXT;
                end
                S_EMIT: state_reg <= S_EMITW;
                S_EMITW:
                begin
                    res_reg <= '{ST_VERTEX, 1'b0, vl_rd, edges_reg,
                                 ({1'b0, kk_reg} + 1'b1 == count_reg)};
                    p_reg <= nl_rd;
                    kk_reg <= kk_reg + 1'b1;
                    state_reg <= ({1'b0, kk_reg} + 1'b1 == count_reg) ? S_IDLE : S_EMIT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/dece_checker.sv
// Port-level checker for the Euler circuit engine, bound to the top level.
// Uses dece_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dece_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   out_valid,
    input dece_pkg::result_item_t result
);
    import dece_pkg::*;
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_out_busy, clk, rst_n, out_valid && !result.last, busy)
    `ASSERT_IMPLY(a_last_fail, clk, rst_n, out_valid && result.status != ST_VERTEX, result.last)
    `ASSERT_IMPLY(a_last_idle, clk, rst_n, out_valid && result.last, !busy)
endmodule

bind directed_euler_circuit_engine dece_checker u_dece_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .result(result));
